>>> design/nearest_palette_pen_selector_unit_assert.svh
// Assertion macros for the nearest palette pen selector.
// Included by the top level; depends on nothing else.
`ifndef NEAREST_PALETTE_PEN_SELECTOR_UNIT_ASSERT_SVH
`define NEAREST_PALETTE_PEN_SELECTOR_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NPPS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("npps check failed");

// The consequent must hold in the cycle after the antecedent.
`define NPPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("npps check failed");

`endif

>>> design/npps_pkg.sv
// Shared types, constants and helper functions of the nearest palette pen selector.
// Depends on nothing; the cell and the top level import it, the interfaces use its widths.
package npps_pkg;

	localparam int RgbW   = 24;
	localparam int DistW  = 18;
	localparam int CountW = 9;
	localparam int IdxW   = 8;
	localparam int SlotW  = 3;
	localparam int SeqW   = 3;

	localparam logic [1:0] REQ_LOAD   = 2'd0;
	localparam logic [1:0] REQ_QUERY  = 2'd1;
	localparam logic [1:0] REQ_PENSET = 2'd2;

	localparam logic [CountW-1:0] PairColours = 9'd2;
	localparam logic [DistW-1:0]  DarkLimit   = 18'd12288;
	localparam logic [DistW-1:0]  BrightLimit = 18'd110592;
	localparam logic [DistW-1:0]  DistOnes    = '1;

	localparam logic [RgbW-1:0] RgbWhite = 24'hFFFFFF;
	localparam logic [RgbW-1:0] RgbBlack = 24'h000000;
	localparam logic [RgbW-1:0] RgbGrey  = 24'h808080;
	localparam logic [RgbW-1:0] RgbDim   = 24'h444444;
	localparam logic [RgbW-1:0] RgbLight = 24'hC0C0C0;
	localparam logic [RgbW-1:0] RgbFill  = 24'h6688BB;

	localparam logic [SlotW-1:0] SlotTerm = 3'd7;

	typedef enum logic [1:0] {
		CLS_DARK,
		CLS_NORMAL,
		CLS_BRIGHT
	} cls_t;

	// A search request travelling down the row of cells.
	typedef struct packed {
		logic              vld;
		logic [SeqW-1:0]   seq;
		logic [RgbW-1:0]   rgb;
		logic [CountW-1:0] limit;
		logic [DistW-1:0]  best_d;
		logic [IdxW-1:0]   idx;
		logic              found;
	} tok_t;

	function automatic logic [15:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] d;
		d = (a > b) ? (a - b) : (b - a);
		return 16'(d) * 16'(d);
	endfunction

	// Target colour of one pen for a palette class.
	function automatic logic [RgbW-1:0] pen_target(input cls_t c, input logic [SlotW-1:0] step);
		logic [RgbW-1:0] t;
		t = RgbBlack;
		case (c)
			CLS_DARK: begin
				case (step)
					3'd1:    t = RgbGrey;
					3'd4:    t = RgbDim;
					3'd5:    t = RgbFill;
					default: t = RgbWhite;
				endcase
			end
			CLS_BRIGHT: begin
				case (step)
					3'd0:    t = RgbGrey;
					3'd3:    t = RgbLight;
					3'd4:    t = RgbGrey;
					3'd5:    t = RgbFill;
					default: t = RgbBlack;
				endcase
			end
			default: begin
				case (step)
					3'd0:    t = RgbGrey;
					3'd3:    t = RgbWhite;
					3'd5:    t = RgbFill;
					default: t = RgbBlack;
				endcase
			end
		endcase
		return t;
	endfunction

	// With a two-colour palette, block, text, shine and fill take the entry nearest white.
	function automatic logic use_shine(input logic [SlotW-1:0] step);
		return step inside {3'd1, 3'd2, 3'd3, 3'd5};
	endfunction

endpackage

>>> design/npps_req_if.sv
// Request channel of the nearest palette pen selector: valid/ready plus payload.
// Depends on npps_pkg for field widths.
interface npps_req_if;
	logic                               valid;
	logic                               ready;
	logic [1:0]                         req_type;
	logic [npps_pkg::IdxW-1:0]          entry_index;
	logic [7:0]                         red;
	logic [7:0]                         green;
	logic [7:0]                         blue;
	logic [npps_pkg::CountW-1:0]        num_colours;

	modport source (output valid, req_type, entry_index, red, green, blue, num_colours,
		input ready);
	modport sink (input valid, req_type, entry_index, red, green, blue, num_colours,
		output ready);
endinterface

>>> design/npps_res_if.sv
// Result channel of the nearest palette pen selector: valid/ready plus payload.
// Depends on npps_pkg for field widths.
interface npps_res_if;
	logic                         valid;
	logic                         ready;
	logic [npps_pkg::SlotW-1:0]   pen_slot;
	logic [npps_pkg::IdxW-1:0]    pen_index;
	logic                         no_pen;
	logic                         last;

	modport source (output valid, pen_slot, pen_index, no_pen, last, input ready);
	modport sink (input valid, pen_slot, pen_index, no_pen, last, output ready);
endinterface

>>> design/npps_cell.sv
// One cell of the palette row: holds one palette entry and compares it against the passing search.
// Depends on npps_pkg.
module npps_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [npps_pkg::CountW-1:0]   pos,
	input  logic                          load_en,
	input  logic [npps_pkg::RgbW-1:0]     load_rgb,
	input  npps_pkg::tok_t                tok_in,
	output npps_pkg::tok_t                tok_out,
	output logic [npps_pkg::RgbW-1:0]     entry
);
	import npps_pkg::*;

	logic [RgbW-1:0]  entry_q;
	logic             vld_q;
	tok_t             tok_q;
	tok_t             tok_nxt;
	logic [DistW-1:0] cand_d;
	logic             take;

	always_comb begin
		cand_d = DistW'(sq_diff(tok_in.rgb[23:16], entry_q[23:16]))
			+ DistW'(sq_diff(tok_in.rgb[15:8], entry_q[15:8]))
			+ DistW'(sq_diff(tok_in.rgb[7:0], entry_q[7:0]));
		// Strict less-than keeps the earlier index on a tie.
		take = tok_in.vld && (pos < tok_in.limit)
			&& (!tok_in.found || (cand_d < tok_in.best_d));
		tok_nxt = tok_in;
		if (take) begin
			tok_nxt.best_d = cand_d;
			tok_nxt.idx    = pos[IdxW-1:0];
			tok_nxt.found  = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_en) begin
			entry_q <= load_rgb;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= tok_in.vld;
		end
	end

	always_ff @(posedge clk) begin
		tok_q <= tok_nxt;
	end

	always_comb begin
		tok_out     = tok_q;
		tok_out.vld = vld_q;
	end

	assign entry = entry_q;

endmodule

>>> design/nearest_palette_pen_selector_unit.sv
// Timing: a load is written at its accepting edge. A query runs one search; a pen set runs two
// (two colours) or seven. Results are handed out once every search has left the cell row,
// then one pen a cycle while results are taken. Loads are taken one a cycle while idle; a
// query or pen set holds off new requests until its last result enters the output register.
// Reset: arst_n clears control state and palette_count; palette entries are undefined until loaded.
`include "nearest_palette_pen_selector_unit_assert.svh"

module nearest_palette_pen_selector_unit #(
	parameter int PALETTE_DEPTH = 256
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [npps_pkg::CountW-1:0] cfg_wdata,
	npps_req_if.sink                    req,
	npps_res_if.source                  res
);
	import npps_pkg::*;

	// The controller walks through four phases. In idle it takes a request. Loads write the
	// addressed cell directly and finish at once. Queries and pen sets then inject one search
	// per target colour into the head of the cell row, wait until every search has come out of
	// the tail, and hand the results out through the output register, one per cycle while taken.
	typedef enum logic [1:0] {
		S_IDLE,
		S_INJECT,
		S_WAIT,
		S_EMIT
	} state_t;

	// Kind of request in progress: a single query, a pen set over a two-colour palette that
	// only needs the nearest-to-white and nearest-to-black searches, or a full pen set with
	// seven searches.
	typedef enum logic [1:0] {
		K_QUERY,
		K_PEN_PAIR,
		K_PEN_FULL
	} kind_t;

	state_t            state_q;
	kind_t             kind_q;
	logic [CountW-1:0] palette_count_q;
	logic [RgbW-1:0]   rgb_q;
	logic [CountW-1:0] limit_q;
	cls_t              cls_q;
	logic [SeqW-1:0]   inj_q;
	logic [SeqW-1:0]   ntok_q;
	logic [SeqW-1:0]   got_q;
	logic [SlotW-1:0]  step_q;
	logic [IdxW-1:0]   res_idx_q [7];
	logic              res_fnd_q [7];

	logic              out_vld_q;
	logic [SlotW-1:0]  out_slot_q;
	logic [IdxW-1:0]   out_idx_q;
	logic              out_none_q;
	logic              out_last_q;

	tok_t              chain [PALETTE_DEPTH+1];
	logic [RgbW-1:0]   entry0;

	logic              accept;
	logic              load_go;
	logic [CountW-1:0] cnt_sat;
	logic [CountW-1:0] limit_next;
	logic [DistW-1:0]  sum_sq;
	cls_t              cls_next;
	logic [RgbW-1:0]   inj_rgb;
	logic              emit_go;
	logic [SeqW-1:0]   sel;
	logic              is_term;
	logic              emit_last;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;

	always_comb begin
		// The register count is used saturated at the palette depth, and the scan covers
		// the smaller of that and the request's colour count.
		cnt_sat = (palette_count_q > CountW'(PALETTE_DEPTH)) ? CountW'(PALETTE_DEPTH)
			: palette_count_q;
		limit_next = (req.num_colours < cnt_sat) ? req.num_colours : cnt_sat;
		load_go = accept && (req.req_type == REQ_LOAD)
			&& (CountW'(req.entry_index) < CountW'(PALETTE_DEPTH));

		// Entry 0 is classed by its sum of squared components when a pen set arrives.
		sum_sq = DistW'(sq_diff(entry0[23:16], 8'd0)) + DistW'(sq_diff(entry0[15:8], 8'd0))
			+ DistW'(sq_diff(entry0[7:0], 8'd0));
		if (sum_sq < DarkLimit) begin
			cls_next = CLS_DARK;
		end else if (sum_sq > BrightLimit) begin
			cls_next = CLS_BRIGHT;
		end else begin
			cls_next = CLS_NORMAL;
		end

		case (kind_q)
			K_QUERY:    inj_rgb = rgb_q;
			K_PEN_PAIR: inj_rgb = (inj_q == '0) ? RgbWhite : RgbBlack;
			default:    inj_rgb = pen_target(cls_q, inj_q);
		endcase

		// A fresh search starts with no candidate and the largest distance.
		chain[0].vld    = (state_q == S_INJECT);
		chain[0].seq    = inj_q;
		chain[0].rgb    = inj_rgb;
		chain[0].limit  = limit_q;
		chain[0].best_d = DistOnes;
		chain[0].idx    = '0;
		chain[0].found  = 1'b0;

		// Each pen slot picks the search whose result it reports. The pair case maps the
		// shine-like slots to the white search and the others to the black search.
		case (kind_q)
			K_QUERY:    sel = '0;
			K_PEN_PAIR: sel = use_shine(step_q) ? SeqW'(0) : SeqW'(1);
			default:    sel = step_q;
		endcase
		is_term   = (kind_q != K_QUERY) && (step_q == SlotTerm);
		emit_last = (kind_q == K_QUERY) || is_term;
		emit_go   = (state_q == S_EMIT) && (!out_vld_q || res.ready);
	end

	for (genvar i = 0; i < PALETTE_DEPTH; i++) begin : g_cell
		logic [RgbW-1:0] entry_w;

		npps_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.pos      (CountW'(i)),
			.load_en  (load_go && (CountW'(req.entry_index) == CountW'(i))),
			.load_rgb ({req.red, req.green, req.blue}),
			.tok_in   (chain[i]),
			.tok_out  (chain[i+1]),
			.entry    (entry_w)
		);

		if (i == 0) begin : g_head
			assign entry0 = entry_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			palette_count_q <= '0;
		end else if (cfg_we) begin
			palette_count_q <= cfg_wdata;
		end
	end

	// Searches leave the tail of the row in injection order; their results are parked by
	// sequence number until the whole request is complete.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			got_q <= '0;
		end else if (accept) begin
			got_q <= '0;
		end else if (chain[PALETTE_DEPTH].vld) begin
			got_q <= got_q + SeqW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (chain[PALETTE_DEPTH].vld) begin
			res_idx_q[chain[PALETTE_DEPTH].seq] <= chain[PALETTE_DEPTH].idx;
			res_fnd_q[chain[PALETTE_DEPTH].seq] <= chain[PALETTE_DEPTH].found;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			kind_q     <= K_QUERY;
			rgb_q      <= '0;
			limit_q    <= '0;
			cls_q      <= CLS_NORMAL;
			inj_q      <= '0;
			ntok_q     <= '0;
			step_q     <= '0;
			out_vld_q  <= 1'b0;
			out_slot_q <= '0;
			out_idx_q  <= '0;
			out_none_q <= 1'b0;
			out_last_q <= 1'b0;
		end else begin
			if (emit_go) begin
				out_vld_q  <= 1'b1;
				out_slot_q <= (kind_q == K_QUERY) ? SlotW'(0) : step_q;
				out_idx_q  <= (is_term || !res_fnd_q[sel]) ? IdxW'(0) : res_idx_q[sel];
				out_none_q <= is_term || !res_fnd_q[sel];
				out_last_q <= emit_last;
			end else if (res.ready) begin
				out_vld_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						rgb_q   <= {req.red, req.green, req.blue};
						limit_q <= limit_next;
						cls_q   <= cls_next;
						inj_q   <= '0;
						step_q  <= '0;
						case (req.req_type)
							REQ_QUERY: begin
								kind_q  <= K_QUERY;
								ntok_q  <= SeqW'(1);
								state_q <= S_INJECT;
							end
							REQ_PENSET: begin
								if (req.num_colours == PairColours) begin
									kind_q <= K_PEN_PAIR;
									ntok_q <= SeqW'(2);
								end else begin
									kind_q <= K_PEN_FULL;
									ntok_q <= SeqW'(7);
								end
								state_q <= S_INJECT;
							end
							default: begin
								// Loads finish at once; the unused request code is dropped.
								// Neither starts a search, so none is owed.
								ntok_q  <= '0;
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_INJECT: begin
					inj_q <= inj_q + SeqW'(1);
					if (inj_q == ntok_q - SeqW'(1)) begin
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (got_q == ntok_q) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (emit_go) begin
						if (emit_last) begin
							state_q <= S_IDLE;
						end else begin
							step_q <= step_q + SlotW'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign res.valid     = out_vld_q;
	assign res.pen_slot  = out_slot_q;
	assign res.pen_index = out_idx_q;
	assign res.no_pen    = out_none_q;
	assign res.last      = out_last_q;

	// A finished search only leaves the row while the controller is still collecting.
	`NPPS_ASSERT_NOW(a_tail_in_search, clk, arst_n, chain[PALETTE_DEPTH].vld, (state_q == S_INJECT) || (state_q == S_WAIT))
	// Never more results collected than searches started.
	`NPPS_ASSERT_NOW(a_got_bounded, clk, arst_n, state_q == S_WAIT, got_q <= ntok_q)
	// When idle, every search of the previous request has been collected.
	`NPPS_ASSERT_NOW(a_idle_drained, clk, arst_n, state_q == S_IDLE, got_q == ntok_q)
	// The terminator pen always closes a pen set.
	`NPPS_ASSERT_NEXT(a_term_last, clk, arst_n, emit_go && is_term, out_vld_q && out_last_q && out_none_q)

endmodule

>>> dv/tb_nearest_palette_pen_selector_unit.sv
// Self-checking testbench for nearest_palette_pen_selector_unit: palette loads, nearest colour
// queries and pen sets, predicted in-line and checked result by result.
// Depends on npps_pkg, npps_req_if, npps_res_if and the design top level.
module tb_nearest_palette_pen_selector_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import npps_pkg::*;

	localparam int PALETTE_DEPTH = 256;
	// Longest time the block may still be busy after the last result it owes.
	localparam int DRAIN_CYCLES = PALETTE_DEPTH + 40;
	// Length of the long result hold-off that fills the block and stalls its input.
	localparam int HOLD_CYCLES = 4 * PALETTE_DEPTH;
	localparam int REPORT_LIMIT = 10;
	// Random requests per traffic phase, on top of the loads that fill the palette.
	localparam int PHASE_REQUESTS = 5;

	// Request type 3 is not defined by the block; it must be dropped without a result.
	localparam logic [1:0] REQ_RESERVED = 2'd3;
	localparam logic [SlotW-1:0] SLOT_TERMINATOR = 3'd7;

	// Target colours per palette class, pens detail..filltext.
	localparam logic [RgbW-1:0] PEN_TARGETS [3][7] = '{
		'{24'hFFFFFF, 24'h808080, 24'hFFFFFF, 24'hFFFFFF, 24'h444444, 24'h6688BB, 24'hFFFFFF},
		'{24'h808080, 24'h000000, 24'h000000, 24'hFFFFFF, 24'h000000, 24'h6688BB, 24'h000000},
		'{24'h808080, 24'h000000, 24'h000000, 24'hC0C0C0, 24'h808080, 24'h6688BB, 24'h000000}
	};
	// With two colours, bit n set means pen n takes the entry nearest white.
	localparam logic [6:0] SHINE_SLOTS = 7'b0101110;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	typedef struct {
		logic [1:0]        kind;
		logic [IdxW-1:0]   entry;
		logic [RgbW-1:0]   rgb;
		logic [CountW-1:0] ncol;
	} pen_request_t;

	typedef struct packed {
		logic [SlotW-1:0] slot;
		logic [IdxW-1:0]  index;
		logic             none;
		logic             last;
	} pen_result_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CountW-1:0] cfg_wdata;

	npps_req_if req_ch();
	npps_res_if res_ch();

	nearest_palette_pen_selector_unit #(
		.PALETTE_DEPTH(PALETTE_DEPTH)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.req      (req_ch),
		.res      (res_ch)
	);

	// Mirror of the block state as the predictor sees it.
	logic [RgbW-1:0]   palette_mirror [PALETTE_DEPTH];
	bit                entry_written [PALETTE_DEPTH];
	logic [CountW-1:0] palette_count_mirror;

	// Pens still owed by the block, oldest first.
	pen_result_t pending_pens[$];

	idle_mode_t  idle_mode;
	int unsigned holds_asked;
	int unsigned mismatch_count;
	int unsigned results_checked;
	int unsigned n_loads, n_queries, n_pen_sets, n_two_colour, n_ignored;
	int unsigned class_seen [3];

	initial begin
		clk = 1'b0;
	end

	always begin
		#1 clk = ~clk;
	end

	function automatic bit chance(input int unsigned pct);
		return $urandom_range(99, 0) < pct;
	endfunction

	function automatic int unsigned sender_idle_pct();
		return (idle_mode == IDLE_SENDER) ? 58 : (idle_mode == IDLE_BOTH) ? 8 : 0;
	endfunction

	function automatic int unsigned receiver_stall_pct();
		return (idle_mode == IDLE_RECEIVER) ? 58 : (idle_mode == IDLE_BOTH) ? 8 : 0;
	endfunction

	// Squared RGB distance between two packed colours.
	function automatic int unsigned colour_distance(input logic [RgbW-1:0] a,
		input logic [RgbW-1:0] b);
		int dr, dg, db;
		dr = int'(a[23:16]) - int'(b[23:16]);
		dg = int'(a[15:8]) - int'(b[15:8]);
		db = int'(a[7:0]) - int'(b[7:0]);
		return dr * dr + dg * dg + db * db;
	endfunction

	// Walks the first span entries; a later entry only wins on a strictly smaller distance,
	// so ties keep the earlier index.
	function automatic void nearest_entry(input logic [RgbW-1:0] rgb, input int unsigned span,
		output bit hit, output logic [IdxW-1:0] idx);
		int unsigned best, d;
		hit = 1'b0;
		idx = '0;
		best = 0;
		for (int unsigned e = 0; e < span; e++) begin
			d = colour_distance(rgb, palette_mirror[e]);
			if (!hit || d < best) begin
				best = d;
				idx = IdxW'(e);
				hit = 1'b1;
			end
		end
	endfunction

	function automatic void push_pen(input int slot, input logic [IdxW-1:0] idx, input bit none,
		input bit last);
		pen_result_t p;
		p.slot = SlotW'(slot);
		p.index = none ? '0 : idx;
		p.none = none;
		p.last = last;
		pending_pens.push_back(p);
	endfunction

	// Applies one accepted request to the mirror and queues the pens it must produce.
	function automatic void predict_request(input pen_request_t r);
		int unsigned cnt, span, energy;
		bit hit, shine_hit, shade_hit;
		logic [IdxW-1:0] idx, shine_idx, shade_idx;
		logic [RgbW-1:0] e0;
		cls_t cls;
		cnt = (palette_count_mirror > PALETTE_DEPTH) ? PALETTE_DEPTH : palette_count_mirror;
		span = (r.ncol < cnt) ? r.ncol : cnt;
		case (r.kind)
			REQ_LOAD: begin
				palette_mirror[r.entry] = r.rgb;
				entry_written[r.entry] = 1'b1;
				n_loads++;
			end
			REQ_QUERY: begin
				nearest_entry(r.rgb, span, hit, idx);
				push_pen(0, idx, !hit, 1'b1);
				n_queries++;
			end
			REQ_PENSET: begin
				n_pen_sets++;
				if (r.ncol == 9'd2) begin
					// Two-colour palettes skip classing: every pen is one of two picks.
					n_two_colour++;
					nearest_entry(24'hFFFFFF, span, shine_hit, shine_idx);
					nearest_entry(24'h000000, span, shade_hit, shade_idx);
					for (int s = 0; s < 7; s++) begin
						if (SHINE_SLOTS[s]) begin
							push_pen(s, shine_idx, !shine_hit, 1'b0);
						end else begin
							push_pen(s, shade_idx, !shade_hit, 1'b0);
						end
					end
				end else begin
					// Entry 0 decides the class even when the scanned range is empty.
					e0 = palette_mirror[0];
					energy = int'(e0[23:16]) * int'(e0[23:16]) + int'(e0[15:8]) * int'(e0[15:8])
						+ int'(e0[7:0]) * int'(e0[7:0]);
					if (energy < DarkLimit) begin
						cls = CLS_DARK;
					end else if (energy > BrightLimit) begin
						cls = CLS_BRIGHT;
					end else begin
						cls = CLS_NORMAL;
					end
					class_seen[int'(cls)]++;
					for (int s = 0; s < 7; s++) begin
						nearest_entry(PEN_TARGETS[int'(cls)][s], span, hit, idx);
						push_pen(s, idx, !hit, 1'b0);
					end
				end
				push_pen(SLOT_TERMINATOR, '0, 1'b1, 1'b1);
			end
			default: begin
				n_ignored++;
			end
		endcase
	endfunction

	// Offers one request from the falling edge on and returns at the accepting rising edge.
	// Valid is left high; the next send or release decides its value at the next falling edge.
	task automatic send_request(input pen_request_t r);
		@(negedge clk);
		while (chance(sender_idle_pct())) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.req_type <= r.kind;
		req_ch.entry_index <= r.entry;
		req_ch.red <= r.rgb[23:16];
		req_ch.green <= r.rgb[15:8];
		req_ch.blue <= r.rgb[7:0];
		req_ch.num_colours <= r.ncol;
		req_ch.valid <= 1'b1;
		@(posedge clk);
		while (req_ch.ready !== 1'b1) begin
			@(posedge clk);
		end
		predict_request(r);
	endtask

	task automatic do_load(input logic [IdxW-1:0] entry, input logic [RgbW-1:0] rgb);
		pen_request_t r;
		r.kind = REQ_LOAD;
		r.entry = entry;
		r.rgb = rgb;
		r.ncol = 9'($urandom_range(511, 0));
		send_request(r);
	endtask

	task automatic do_query(input logic [RgbW-1:0] rgb, input logic [CountW-1:0] ncol);
		pen_request_t r;
		r.kind = REQ_QUERY;
		r.entry = 8'($urandom_range(255, 0));
		r.rgb = rgb;
		r.ncol = ncol;
		send_request(r);
	endtask

	task automatic do_pen_set(input logic [CountW-1:0] ncol);
		pen_request_t r;
		r.kind = REQ_PENSET;
		r.entry = 8'($urandom_range(255, 0));
		r.rgb = 24'($urandom());
		r.ncol = ncol;
		send_request(r);
	endtask

	task automatic do_reserved();
		pen_request_t r;
		r.kind = REQ_RESERVED;
		r.entry = 8'($urandom_range(255, 0));
		r.rgb = 24'($urandom());
		r.ncol = 9'($urandom_range(511, 0));
		send_request(r);
	endtask

	// Drops valid, waits for every owed pen, then lets the block finish any trailing load.
	task automatic settle();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending_pens.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// The register may only change while the block is idle.
	task automatic set_palette_count(input logic [CountW-1:0] value);
		settle();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		palette_count_mirror = value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Mostly dark, bright or grid colours so that classes and exact ties both show up.
	function automatic logic [RgbW-1:0] pick_colour();
		int unsigned style;
		logic [7:0] c [3];
		style = $urandom_range(99, 0);
		for (int k = 0; k < 3; k++) begin
			if (style < 30) begin
				c[k] = 8'($urandom_range(255, 0));
			end else if (style < 55) begin
				c[k] = 8'($urandom_range(63, 0));
			end else if (style < 80) begin
				c[k] = 8'($urandom_range(255, 193));
			end else begin
				case ($urandom_range(4, 0))
					0: c[k] = 8'h00;
					1: c[k] = 8'h44;
					2: c[k] = 8'h80;
					3: c[k] = 8'hC0;
					default: c[k] = 8'hFF;
				endcase
			end
		end
		return {c[0], c[1], c[2]};
	endfunction

	// Colour counts cluster around the two-colour case, zero and the loaded count.
	function automatic logic [CountW-1:0] pick_colour_count(input int unsigned cnt);
		int unsigned roll;
		roll = $urandom_range(99, 0);
		if (roll < 15) begin
			return 9'd2;
		end
		if (roll < 25) begin
			return 9'd0;
		end
		if (roll < 50) begin
			return 9'($urandom_range(cnt + 2, (cnt > 2) ? cnt - 2 : 0));
		end
		return 9'($urandom_range(511, 0));
	endfunction

	// Empty range right after reset: only entry 0 exists, and it is needed for classing.
	task automatic test_empty_palette();
		do_load(8'd0, 24'h000000);
		do_query(24'h123456, 9'd256);
		do_pen_set(9'd256);
		do_pen_set(9'd2);
	endtask

	// Duplicate entries check that the earlier index wins; a zero colour count gives no pen.
	task automatic test_ties_and_extremes();
		set_palette_count(9'd4);
		do_load(8'd0, 24'h404040);
		do_load(8'd1, 24'hFFFFFF);
		do_load(8'd2, 24'h000000);
		do_load(8'd3, 24'hFFFFFF);
		do_query(24'hFFFFFF, 9'd511);
		do_query(24'h000000, 9'd256);
		do_query(24'hFF00FF, 9'd0);
		do_reserved();
		do_load(8'd255, 24'hFF00FF);
	endtask

	// Entry 0 is moved across both class boundaries; 0x40 and 0xC0 grey sit exactly on them
	// and still class as normal.
	task automatic test_palette_classes();
		do_pen_set(9'd2);
		do_pen_set(9'd4);
		do_load(8'd0, 24'hC0C0C0);
		do_pen_set(9'd3);
		do_load(8'd0, 24'hC1C1C1);
		do_pen_set(9'd256);
		do_load(8'd0, 24'h3F3F3F);
		do_pen_set(9'd256);
	endtask

	// The result side holds off for a long stretch while requests keep coming, so the block
	// fills and has to stall its request input.
	task automatic test_output_backpressure();
		idle_mode = IDLE_NONE;
		holds_asked++;
		for (int k = 0; k < 6; k++) begin
			if (k % 2 == 0) begin
				do_query(pick_colour(), 9'd4);
			end else begin
				do_pen_set(9'($urandom_range(6, 0)));
			end
		end
		settle();
	endtask

	// Phases with different palette sizes and idle patterns; every entry a scan can reach is
	// loaded before the first search of the phase.
	task automatic test_random_traffic();
		int unsigned counts [10];
		int unsigned cnt, budget, roll, e;
		logic [RgbW-1:0] rgb;
		counts = '{16, 2, 1, 256, 7, 511, 0, 64, 300, 0};
		counts[9] = $urandom_range(256, 3);
		for (int p = 0; p < 10; p++) begin
			set_palette_count(9'(counts[p]));
			idle_mode = idle_mode_t'(p % 4);
			cnt = (counts[p] > PALETTE_DEPTH) ? PALETTE_DEPTH : counts[p];
			for (int unsigned k = 0; k < cnt; k++) begin
				if (!entry_written[k]) begin
					do_load(8'(k), pick_colour());
				end
			end
			budget = 0;
			while (budget < PHASE_REQUESTS) begin
				roll = $urandom_range(99, 0);
				if (roll < 15) begin
					if (cnt != 0 && chance(70)) begin
						do_load(8'($urandom_range(cnt - 1, 0)), pick_colour());
					end else begin
						do_load(8'($urandom_range(255, 0)), pick_colour());
					end
					budget++;
				end else if (roll < 65) begin
					rgb = chance(60) ? 24'($urandom()) : pick_colour();
					// Sometimes ask for a colour that is already loaded, for an exact match.
					if (cnt != 0 && chance(30)) begin
						e = $urandom_range(cnt - 1, 0);
						rgb = palette_mirror[e];
					end
					do_query(rgb, pick_colour_count(cnt));
					budget++;
				end else if (roll < 95) begin
					do_pen_set(pick_colour_count(cnt));
					budget++;
				end else begin
					do_reserved();
				end
			end
		end
	endtask

	// Result side: ready changes at the falling edge, either held off on request or random.
	initial begin : result_drain
		int unsigned hold_left;
		int unsigned holds_served;
		hold_left = 0;
		holds_served = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (holds_served != holds_asked) begin
				holds_served = holds_asked;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= !chance(receiver_stall_pct());
			end
		end
	end

	// Every accepted pen is compared with the oldest owed one.
	always @(posedge clk) begin : pen_checker
		pen_result_t got, want;
		if (arst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			got.slot = res_ch.pen_slot;
			got.index = res_ch.pen_index;
			got.none = res_ch.no_pen;
			got.last = res_ch.last;
			if (pending_pens.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT) begin
					$display("unexpected pen: slot %0d index %0d no_pen %0b last %0b",
						got.slot, got.index, got.none, got.last);
				end
			end else begin
				want = pending_pens.pop_front();
				results_checked++;
				if (got.slot !== want.slot || got.index !== want.index
					|| got.none !== want.none || got.last !== want.last) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT) begin
						$display("pen mismatch: expected slot %0d index %0d no_pen %0b last %0b",
							want.slot, want.index, want.none, want.last);
						$display("                   got slot %0d index %0d no_pen %0b last %0b",
							got.slot, got.index, got.none, got.last);
					end
				end
			end
		end
	end

	initial begin : run_limit
		#3_000_000;
		$display("Run limit reached with %0d pens still owed.", pending_pens.size());
		$display("FAIL nearest_palette_pen_selector_unit");
		$finish;
	end

	initial begin : stimulus
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_LOAD;
		req_ch.entry_index = '0;
		req_ch.red = '0;
		req_ch.green = '0;
		req_ch.blue = '0;
		req_ch.num_colours = '0;
		palette_count_mirror = '0;
		idle_mode = IDLE_NONE;
		holds_asked = 0;
		mismatch_count = 0;
		results_checked = 0;
		n_loads = 0;
		n_queries = 0;
		n_pen_sets = 0;
		n_two_colour = 0;
		n_ignored = 0;
		class_seen = '{0, 0, 0};
		for (int k = 0; k < PALETTE_DEPTH; k++) begin
			palette_mirror[k] = '0;
			entry_written[k] = 1'b0;
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_palette();
		test_ties_and_extremes();
		test_palette_classes();
		test_output_backpressure();
		test_random_traffic();
		settle();

		$display("Sent %0d loads, %0d queries, %0d pen sets (%0d two-colour), %0d ignored.",
			n_loads, n_queries, n_pen_sets, n_two_colour, n_ignored);
		$display("Checked %0d pens; classed pen sets dark/normal/bright: %0d/%0d/%0d.",
			results_checked, class_seen[0], class_seen[1], class_seen[2]);
		if (mismatch_count == 0 && pending_pens.size() == 0) begin
			$display("PASS nearest_palette_pen_selector_unit");
		end else begin
			$display("%0d mismatches, %0d pens never arrived.", mismatch_count,
				pending_pens.size());
			$display("FAIL nearest_palette_pen_selector_unit");
		end
		$finish;
	end

endmodule
